// ----- rtl/core/mpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Mulliken population accumulator package
// Shared types and constants for the population accumulator block.
// ----------------------------------------------------------------------------
package mpa_pkg;

    localparam int MAX_ORBITALS  = 64;
    localparam int ELEMENT_WIDTH = 32;
    localparam int FRAC_BITS     = 28;
    localparam int OCC_FRAC      = 16;
    localparam int VEC_WIDTH     = 40;
    localparam int ACC_WIDTH     = 48;
    localparam int OCC_WIDTH     = 18;

    typedef enum logic [2:0] {
        FUNC_WR_OVL  = 3'd0,
        FUNC_WR_EIG  = 3'd1,
        FUNC_WR_OCC  = 3'd2,
        FUNC_CLEAR   = 3'd3,
        FUNC_RUN     = 3'd4,
        FUNC_RD_POP  = 3'd5,
        FUNC_BAD6    = 3'd6,
        FUNC_BAD7    = 3'd7
    } t_func;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_OCC,
        ST_VRD,
        ST_VMUL,
        ST_VACC,
        ST_VEND,
        ST_SRD,
        ST_SMUL,
        ST_SFAC,
        ST_SACC,
        ST_NEXT,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/core/mpa_qmul.sv -----
// ----------------------------------------------------------------------------
// Rounded fixed-point multiplier
// Multiplies a 32-bit signed element by a 40-bit signed value with registered
// partial products and rounds to 28 fraction bits, half away from zero.
// ----------------------------------------------------------------------------
module mpa_qmul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [39:0] i_b,
    output logic signed [63:0] o_p
);

    logic [31:0] w_ma;
    logic [39:0] w_mb;
    logic        r_neg;
    logic [51:0] r_ph;
    logic [51:0] r_pl;
    logic [63:0] w_mag;

    assign w_ma = i_a[31] ? 32'(-i_a) : 32'(i_a);
    assign w_mb = i_b[39] ? 40'(-i_b) : 40'(i_b);

    always_ff @(posedge i_clk) begin
        r_neg <= i_a[31] ^ i_b[39];
        r_ph  <= 52'(w_ma) * 52'(w_mb[39:20]);
        r_pl  <= 52'(w_ma) * 52'(w_mb[19:0]);
    end

    assign w_mag = 64'(r_ph >> 8)
                 + ((64'({r_ph[7:0], 20'd0}) + 64'(r_pl)
                    + 64'(1 << (mpa_pkg::FRAC_BITS - 1))) >> mpa_pkg::FRAC_BITS);
    assign o_p = r_neg ? -$signed(w_mag) : $signed(w_mag);

endmodule

// ----- rtl/core/mulliken_population_accumulate_unit.sv -----
// ----------------------------------------------------------------------------
// Mulliken population accumulate unit
// Loads overlap, eigenvector and occupation stores and accumulates
// per-orbital populations with one shared rounded multiplier.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// input     in         i_valid, o_stall, i_func .. i_occupation_value
// output    out        o_valid, i_stall, o_status, o_orbital_index, o_population
// config    in         i_cfg_we, i_cfg_data
// Loads, clears, reads and errors pass from IDLE through CLR to OUT.
// A run makes a vector pass and a share pass for each occupied state and
// skips each empty state, all on the one multiplier.
// Reset is synchronous; accumulators start at zero without a clearing pass.
// The input is stalled from acceptance until the result is taken.
// ----------------------------------------------------------------------------
module mulliken_population_accumulate_unit #(
    parameter int ELEMENT_WIDTH = mpa_pkg::ELEMENT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic [5:0]         i_row_index,
    input  logic [5:0]         i_col_index,
    input  logic signed [31:0] i_value_real,
    input  logic signed [31:0] i_value_imag,
    input  logic [17:0]        i_occupation_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [5:0]         o_orbital_index,
    output logic signed [47:0] o_population
);

    localparam int MAX_ORBITALS = mpa_pkg::MAX_ORBITALS;
    localparam int IW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
    localparam int CW = $clog2(MAX_ORBITALS + 1);
    localparam int VW = mpa_pkg::VEC_WIDTH;
    localparam int AW = mpa_pkg::ACC_WIDTH;

    logic [63:0]       m_ovl [MAX_ORBITALS*MAX_ORBITALS];
    logic [63:0]       m_eig [MAX_ORBITALS*MAX_ORBITALS];
    logic [17:0]       m_occ [MAX_ORBITALS];
    logic [AW-1:0]     m_acc [MAX_ORBITALS];
    logic [2*VW-1:0]   m_vec [MAX_ORBITALS];
    logic [MAX_ORBITALS-1:0] r_accv;

    mpa_pkg::t_state r_st, n_st;
    logic [6:0]    r_cnt;
    logic [CW-1:0] w_n;
    logic [2:0]    r_func;
    logic [5:0]    r_row, r_col;
    logic [31:0]   r_vr, r_vi;
    logic [17:0]   r_occv;
    logic [IW-1:0] r_i, r_mu, r_nu;
    logic [1:0]    r_ph;
    logic          r_hit;
    logic [1:0]    r_status;
    logic [5:0]    r_oidx;
    logic [AW-1:0] r_pop;
    logic          r_ovalid;
    logic [63:0]   r_sd, r_cd;
    logic [2*VW-1:0] r_vd;
    logic [AW-1:0] r_ad;
    logic [17:0]   r_od, r_f;
    logic signed [63:0] r_sr, r_si;
    logic signed [31:0] w_ma;
    logic signed [39:0] w_mb;
    logic signed [63:0] w_p;
    logic signed [63:0] r_share;
    logic [43:0]   w_smag;
    logic [63:0]   r_dmag;
    logic          w_rowok, w_colok;

    mpa_qmul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_p));

    always_comb begin
        if (r_cnt == 7'd0) begin
            w_n = CW'(1);
        end else if (32'(r_cnt) > MAX_ORBITALS) begin
            w_n = CW'(MAX_ORBITALS);
        end else begin
            w_n = CW'(r_cnt);
        end
    end

    assign w_rowok = 32'(r_row) < 32'(w_n);
    assign w_colok = 32'(r_col) < 32'(w_n);

    function automatic logic signed [31:0] f_el(input logic [31:0] v);
        return 32'($signed(v[ELEMENT_WIDTH-1:0]));
    endfunction

    // Operand select: r_ph steps through the four partial products of the vector pass and the two of the share pass.
    always_comb begin
        unique case (r_st)
            mpa_pkg::ST_SMUL, mpa_pkg::ST_SFAC, mpa_pkg::ST_SACC: begin
                w_ma = (r_ph[0]) ? $signed(r_cd[31:0]) : $signed(r_cd[63:32]);
                w_mb = (r_ph[0]) ? $signed(r_vd[VW-1:0]) : $signed(r_vd[2*VW-1:VW]);
            end
            default: begin
                w_ma = r_ph[1] ? $signed(r_sd[31:0]) : $signed(r_sd[63:32]);
                w_mb = 40'($signed(r_ph[0] ^ r_ph[1] ? r_cd[31:0] : r_cd[63:32]));
            end
        endcase
    end

    logic signed [63:0] w_lo, w_hi;
    assign w_hi = 64'sd549755813887;
    assign w_lo = -64'sd549755813888;

    logic signed [63:0] w_acc_sum;
    logic signed [63:0] w_d;
    assign w_d = r_share[63] ? -$signed(r_dmag) : $signed(r_dmag);
    assign w_acc_sum = 64'($signed(r_ad)) + w_d;
    assign w_smag = r_share[63] ? 44'(-r_share) : 44'(r_share);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= mpa_pkg::ST_IDLE;
            r_cnt    <= 7'd64;
            r_ovalid <= 1'b0;
            r_accv   <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                r_cnt <= i_cfg_data;
            end
            if (r_st == mpa_pkg::ST_OUT && !i_stall) begin
                r_ovalid <= 1'b0;
            end else if (n_st == mpa_pkg::ST_OUT && r_st != mpa_pkg::ST_OUT) begin
                r_ovalid <= 1'b1;
            end
            if (r_st == mpa_pkg::ST_CLR && r_func == mpa_pkg::FUNC_CLEAR) begin
                r_accv <= '0;
            end else if (r_st == mpa_pkg::ST_SACC && r_ph == 2'd0) begin
                r_accv[r_mu] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            mpa_pkg::ST_IDLE: begin
                r_func <= i_func; r_row <= i_row_index; r_col <= i_col_index;
                r_vr <= i_value_real; r_vi <= i_value_imag; r_occv <= i_occupation_value;
                r_i <= '0; r_mu <= '0; r_nu <= '0; r_ph <= '0;
                r_hit <= 1'b0; r_status <= mpa_pkg::STAT_OK;
                r_oidx <= '0; r_pop <= '0;
            end
            mpa_pkg::ST_CLR: begin
                r_status <= mpa_pkg::STAT_OK;
                unique case (mpa_pkg::t_func'(r_func))
                    mpa_pkg::FUNC_WR_OVL, mpa_pkg::FUNC_WR_EIG: begin
                        if (w_rowok && w_colok) begin
                            if (r_func == mpa_pkg::FUNC_WR_OVL) begin
                                m_ovl[{r_row[IW-1:0], r_col[IW-1:0]}] <=
                                    {f_el(r_vr), f_el(r_vi)};
                            end else begin
                                m_eig[{r_row[IW-1:0], r_col[IW-1:0]}] <=
                                    {f_el(r_vr), f_el(r_vi)};
                            end
                        end else begin
                            r_status <= mpa_pkg::STAT_RANGE;
                        end
                    end
                    mpa_pkg::FUNC_WR_OCC: begin
                        if (w_rowok) m_occ[r_row[IW-1:0]] <= r_occv;
                        else r_status <= mpa_pkg::STAT_RANGE;
                    end
                    mpa_pkg::FUNC_CLEAR, mpa_pkg::FUNC_RUN: ;
                    mpa_pkg::FUNC_RD_POP: begin
                        if (w_rowok) begin
                            r_oidx <= r_row;
                            r_pop <= r_accv[r_row[IW-1:0]] ? m_acc[r_row[IW-1:0]] : '0;
                        end else begin
                            r_status <= mpa_pkg::STAT_RANGE;
                        end
                    end
                    default: r_status <= mpa_pkg::STAT_RANGE;
                endcase
            end
            mpa_pkg::ST_OCC: begin
                r_od <= m_occ[r_i];
            end
            mpa_pkg::ST_VRD: begin
                r_sd <= m_ovl[{r_mu, r_nu}];
                r_cd <= m_eig[{r_nu, r_i}];
                r_ph <= '0;
                if (r_nu == '0) begin r_sr <= '0; r_si <= '0; end
            end
            mpa_pkg::ST_VMUL: begin
                r_ph <= r_ph + 2'd1;
            end
            mpa_pkg::ST_VACC: begin
                // Products arrive in the cycle after their operands.
                unique case (r_ph)
                    2'd1: r_sr <= r_sr + w_p;
                    2'd2: r_si <= r_si + w_p;
                    2'd3: r_sr <= r_sr - w_p;
                    2'd0: r_si <= r_si + w_p;
                endcase
                r_ph <= r_ph + 2'd1;
                if (r_ph == 2'd0) r_nu <= r_nu + IW'(1);
            end
            mpa_pkg::ST_VEND: begin
                m_vec[r_mu] <= {(r_sr > w_hi) ? w_hi[VW-1:0] : (r_sr < w_lo) ? w_lo[VW-1:0]
                                    : r_sr[VW-1:0],
                                (r_si > w_hi) ? w_hi[VW-1:0] : (r_si < w_lo) ? w_lo[VW-1:0]
                                    : r_si[VW-1:0]};
                if (r_sr > w_hi || r_sr < w_lo || r_si > w_hi || r_si < w_lo) r_hit <= 1'b1;
                r_nu <= '0;
                r_mu <= w_lastmu ? '0 : r_mu + IW'(1);
            end
            mpa_pkg::ST_SRD: begin
                r_cd <= m_eig[{r_mu, r_i}];
                r_vd <= m_vec[r_mu];
                r_ad <= r_accv[r_mu] ? m_acc[r_mu] : '0;
                r_f  <= r_od;
                r_ph <= '0;
            end
            mpa_pkg::ST_SMUL: r_ph <= r_ph + 2'd1;
            mpa_pkg::ST_SFAC: begin
                if (r_ph == 2'd1) r_share <= w_p;
                else r_share <= r_share + w_p;
                r_ph <= r_ph + 2'd1;
            end
            mpa_pkg::ST_SACC: begin
                if (r_ph == 2'd0) begin
                    if (w_acc_sum > 64'sd140737488355327) begin
                        m_acc[r_mu] <= {1'b0, {(AW-1){1'b1}}}; r_hit <= 1'b1;
                    end else if (w_acc_sum < -64'sd140737488355328) begin
                        m_acc[r_mu] <= {1'b1, {(AW-1){1'b0}}}; r_hit <= 1'b1;
                    end else begin
                        m_acc[r_mu] <= w_acc_sum[AW-1:0];
                    end
                    r_mu <= r_mu + IW'(1);
                end else begin
                    r_dmag <= (64'(r_f) * 64'(w_smag)
                               + 64'(1 << (mpa_pkg::OCC_FRAC - 1))) >> mpa_pkg::OCC_FRAC;
                end
                r_ph <= r_ph + 2'd1;
            end
            mpa_pkg::ST_NEXT: begin
                r_mu <= '0; r_nu <= '0;
                r_i <= r_i + IW'(1);
                if (32'(r_i) + 1 >= 32'(w_n)) r_status <= r_hit ? mpa_pkg::STAT_SAT
                                                                  : mpa_pkg::STAT_OK;
            end
            mpa_pkg::ST_OUT: ;
            default: ;
        endcase
    end

    logic w_lastmu, w_lastnu, w_lasti;
    assign w_lastmu = 32'(r_mu) + 1 >= 32'(w_n);
    assign w_lastnu = 32'(r_nu) + 1 >= 32'(w_n);
    assign w_lasti  = 32'(r_i) + 1 >= 32'(w_n);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mpa_pkg::ST_IDLE: if (i_valid) n_st = mpa_pkg::ST_CLR;
            mpa_pkg::ST_CLR: begin
                if (r_func == mpa_pkg::FUNC_RUN) n_st = mpa_pkg::ST_OCC;
                else n_st = mpa_pkg::ST_OUT;
            end
            mpa_pkg::ST_OCC: n_st = mpa_pkg::ST_VRD;
            mpa_pkg::ST_VRD: n_st = (r_od == '0) ? mpa_pkg::ST_NEXT : mpa_pkg::ST_VMUL;
            mpa_pkg::ST_VMUL: n_st = mpa_pkg::ST_VACC;
            mpa_pkg::ST_VACC: begin
                if (r_ph == 2'd0) n_st = w_lastnu ? mpa_pkg::ST_VEND : mpa_pkg::ST_VRD;
            end
            mpa_pkg::ST_VEND: n_st = w_lastmu ? mpa_pkg::ST_SRD : mpa_pkg::ST_VRD;
            mpa_pkg::ST_SRD: n_st = mpa_pkg::ST_SMUL;
            mpa_pkg::ST_SMUL: n_st = mpa_pkg::ST_SFAC;
            mpa_pkg::ST_SFAC: if (r_ph == 2'd2) n_st = mpa_pkg::ST_SACC;
            mpa_pkg::ST_SACC: begin
                if (r_ph == 2'd0) n_st = w_lastmu ? mpa_pkg::ST_NEXT : mpa_pkg::ST_SRD;
            end
            mpa_pkg::ST_NEXT: n_st = w_lasti ? mpa_pkg::ST_OUT : mpa_pkg::ST_OCC;
            mpa_pkg::ST_OUT: if (!i_stall) n_st = mpa_pkg::ST_IDLE;
            default: n_st = mpa_pkg::ST_IDLE;
        endcase
    end

    assign o_stall         = (r_st != mpa_pkg::ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_orbital_index = r_oidx;
    assign o_population    = $signed(r_pop);

endmodule

// ----- test/mulliken_population_accumulate_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Mulliken population accumulate unit testbench
// Drives a table of directed transactions and then random phases at several
// matrix dimensions. Every result is compared with the expected value in the
// table or with a cycle-free model of the complex population accumulation in the testbench.
// ----------------------------------------------------------------------------
module mulliken_population_accumulate_unit_tb;

    localparam int  LIMIT    = 1500000;
    localparam bit  ROW_TXN  = 1'b0;
    localparam bit  ROW_CFG  = 1'b1;
    localparam bit  FILL_RND = 1'b0;
    localparam bit  FILL_MAX = 1'b1;
    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh10000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  idx;
        logic [47:0] pop;
    } t_pop_result;

    typedef struct {
        bit                 kind;
        mpa_pkg::t_func     func;
        logic [6:0]         row;
        logic [5:0]         col;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [17:0]        occ;
        bit                 chk;
        t_pop_result        res;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [6:0]         i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_func = '0;
    logic [5:0]         i_row_index = '0;
    logic [5:0]         i_col_index = '0;
    logic signed [31:0] i_value_real = '0;
    logic signed [31:0] i_value_imag = '0;
    logic [17:0]        i_occupation_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic [5:0]         o_orbital_index;
    logic signed [47:0] o_population;

    mulliken_population_accumulate_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_value_real(i_value_real), .i_value_imag(i_value_imag),
        .i_occupation_value(i_occupation_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_orbital_index(o_orbital_index), .o_population(o_population)
    );

    always #4 i_clk = ~i_clk;

    longint      ovl_re [64][64], ovl_im [64][64], eig_re [64][64], eig_im [64][64];
    longint      occ_q [64];
    longint      pop_acc [64];
    bit          ovl_w [64][64], eig_w [64][64], occ_w [64];
    int          dim_n = 64;
    t_pop_result pending_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    t_stim_row   dir_tab [$];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint rmul(longint a, longint b);
        logic [79:0] ma, mb, p;
        longint      r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p  = (ma * mb + (80'd1 << (mpa_pkg::FRAC_BITS - 1))) >> mpa_pkg::FRAC_BITS;
        r  = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint clip(longint x, int w, inout bit hit);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin hit = 1'b1; return hi; end
        if (x < lo) begin hit = 1'b1; return lo; end
        return x;
    endfunction

    function automatic bit accumulate_populations();
        longint      vr [64], vi [64];
        longint      sr, si, share, d;
        logic [79:0] p;
        bit          hit;
        hit = 1'b0;
        for (int i = 0; i < dim_n; i++) begin
            if (occ_q[i] == 0) continue;
            for (int mu = 0; mu < dim_n; mu++) begin
                sr = 0;
                si = 0;
                for (int nu = 0; nu < dim_n; nu++) begin
                    sr += rmul(ovl_re[mu][nu], eig_re[nu][i]) - rmul(ovl_im[mu][nu], eig_im[nu][i]);
                    si += rmul(ovl_re[mu][nu], eig_im[nu][i]) + rmul(ovl_im[mu][nu], eig_re[nu][i]);
                end
                vr[mu] = clip(sr, mpa_pkg::VEC_WIDTH, hit);
                vi[mu] = clip(si, mpa_pkg::VEC_WIDTH, hit);
            end
            for (int mu = 0; mu < dim_n; mu++) begin
                share = rmul(eig_re[mu][i], vr[mu]) + rmul(eig_im[mu][i], vi[mu]);
                p = 80'(occ_q[i]) * 80'((share < 0) ? -share : share);
                p = (p + (80'd1 << (mpa_pkg::OCC_FRAC - 1))) >> mpa_pkg::OCC_FRAC;
                d = longint'(p[63:0]);
                if (share < 0) d = -d;
                pop_acc[mu] = clip(pop_acc[mu] + d, mpa_pkg::ACC_WIDTH, hit);
            end
        end
        return hit;
    endfunction

    function automatic t_pop_result predict_population(mpa_pkg::t_func f, logic [5:0] row,
            logic [5:0] col, logic signed [31:0] re, logic signed [31:0] im,
            logic [17:0] occ);
        t_pop_result r;
        r = '0;
        case (f)
            mpa_pkg::FUNC_WR_OVL, mpa_pkg::FUNC_WR_EIG: begin
                if (row < dim_n && col < dim_n) begin
                    if (f == mpa_pkg::FUNC_WR_OVL) begin
                        ovl_re[row][col] = re;
                        ovl_im[row][col] = im;
                        ovl_w[row][col]  = 1'b1;
                    end else begin
                        eig_re[row][col] = re;
                        eig_im[row][col] = im;
                        eig_w[row][col]  = 1'b1;
                    end
                end else begin
                    r.status = mpa_pkg::STAT_RANGE;
                end
            end
            mpa_pkg::FUNC_WR_OCC: begin
                if (row < dim_n) begin
                    occ_q[row] = occ;
                    occ_w[row] = 1'b1;
                end else begin
                    r.status = mpa_pkg::STAT_RANGE;
                end
            end
            mpa_pkg::FUNC_CLEAR: begin
                foreach (pop_acc[k]) pop_acc[k] = 0;
            end
            mpa_pkg::FUNC_RUN: begin
                r.status = accumulate_populations() ? mpa_pkg::STAT_SAT : mpa_pkg::STAT_OK;
            end
            mpa_pkg::FUNC_RD_POP: begin
                if (row < dim_n) begin
                    r.idx = row;
                    r.pop = pop_acc[row][47:0];
                end else begin
                    r.status = mpa_pkg::STAT_RANGE;
                end
            end
            default: r.status = mpa_pkg::STAT_RANGE;
        endcase
        return r;
    endfunction

    function automatic bit stores_ready();
        for (int i = 0; i < dim_n; i++) begin
            if (!occ_w[i]) return 1'b0;
            for (int j = 0; j < dim_n; j++) begin
                if (!ovl_w[i][j]) return 1'b0;
                if (occ_q[j] != 0 && !eig_w[i][j]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_txn(mpa_pkg::t_func f, logic [5:0] row, logic [5:0] col,
            logic signed [31:0] re, logic signed [31:0] im, logic [17:0] occ,
            bit use_tab, t_pop_result tab);
        int          gap;
        t_pop_result r;
        gap = no_idle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func             = f;
        i_row_index        = row;
        i_col_index        = col;
        i_value_real       = re;
        i_value_imag       = im;
        i_occupation_value = occ;
        i_valid            = 1'b1;
        do @(posedge i_clk); while (o_stall);
        r = predict_population(f, row, col, re, im, occ);
        pending_q.push_back(use_tab ? tab : r);
    endtask

    task automatic write_dimension(logic [6:0] value);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        dim_n = (value == 0) ? 1 : (value > 64) ? 64 : value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VMAX;
            1: return VMIN;
            2: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] pick_index();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, dim_n - 1);
        return $urandom_range(0, 63);
    endfunction

    task automatic fill_stores(bit mode);
        logic [17:0] occ;
        for (int i = 0; i < dim_n; i++) begin
            for (int j = 0; j < dim_n; j++) begin
                if (mode == FILL_MAX) begin
                    send_txn(mpa_pkg::FUNC_WR_OVL, i, j, VMIN, VMIN, 0, 1'b0, '0);
                    send_txn(mpa_pkg::FUNC_WR_EIG, i, j, VMIN, VMAX, 0, 1'b0, '0);
                end else begin
                    send_txn(mpa_pkg::FUNC_WR_OVL, i, j, $urandom, $urandom, 0, 1'b0, '0);
                    send_txn(mpa_pkg::FUNC_WR_EIG, i, j, $urandom, $urandom, 0, 1'b0, '0);
                end
            end
            if (mode == FILL_MAX) occ = 18'h3ffff;
            else if ($urandom_range(0, 3) == 0) occ = 0;
            else occ = $urandom;
            send_txn(mpa_pkg::FUNC_WR_OCC, i, 0, 0, 0, occ, 1'b0, '0);
        end
    endtask

    task automatic random_txn();
        int             r;
        mpa_pkg::t_func f;
        r = $urandom_range(0, 99);
        if (r < 20)       f = mpa_pkg::FUNC_WR_OVL;
        else if (r < 38)  f = mpa_pkg::FUNC_WR_EIG;
        else if (r < 50)  f = mpa_pkg::FUNC_WR_OCC;
        else if (r < 72)  f = mpa_pkg::FUNC_RD_POP;
        else if (r < 88)  f = stores_ready() ? mpa_pkg::FUNC_RUN : mpa_pkg::FUNC_RD_POP;
        else if (r < 93)  f = mpa_pkg::FUNC_CLEAR;
        else              f = ($urandom_range(0, 1) == 0) ? mpa_pkg::FUNC_BAD6
                                                          : mpa_pkg::FUNC_BAD7;
        send_txn(f, pick_index(), pick_index(), pick_value(), pick_value(),
                 ($urandom_range(0, 4) == 0) ? 18'd0 : 18'($urandom), 1'b0, '0);
    endtask

    function automatic t_stim_row mk(bit kind, mpa_pkg::t_func f, logic [6:0] row,
            logic [5:0] col, logic signed [31:0] re, logic signed [31:0] im,
            logic [17:0] occ, bit chk, logic [1:0] st, logic [5:0] idx, logic [47:0] pop);
        t_stim_row s;
        s.kind = kind; s.func = f; s.row = row; s.col = col;
        s.re = re; s.im = im; s.occ = occ; s.chk = chk;
        s.res.status = st; s.res.idx = idx; s.res.pop = pop;
        return s;
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 9) < 3) begin
            i_stall    <= 1'b1;
            stall_left <= pick_gap();
        end else begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        t_pop_result e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected result: status %0d", o_status);
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.status || o_orbital_index !== e.idx ||
                    o_population !== e.pop) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: exp %0d/%0d/%h got %0d/%0d/%h", e.status,
                                 e.idx, e.pop, o_status, o_orbital_index, o_population);
                end
            end
        end
    end

    initial begin
        int        dims [8] = '{3, 8, 5, 127, 2, 6, 1, 4};
        t_stim_row s;
        foreach (pop_acc[k]) begin
            pop_acc[k] = 0;
            occ_q[k]   = 0;
            occ_w[k]   = 1'b0;
        end
        foreach (ovl_w[a, b]) begin
            ovl_w[a][b] = 1'b0; eig_w[a][b] = 1'b0;
            ovl_re[a][b] = 0; ovl_im[a][b] = 0; eig_re[a][b] = 0; eig_im[a][b] = 0;
        end

        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RD_POP, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RD_POP, 63, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 63, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_BAD6, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_RANGE, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_BAD7, 63, 63, VMAX, VMAX, 18'h3ffff,
                             1, mpa_pkg::STAT_RANGE, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OVL, 63, 63, VMAX, VMAX, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_EIG, 0, 0, VMIN, VMIN, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OCC, 63, 0, 0, 0, 18'h3ffff, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_CFG, mpa_pkg::FUNC_RD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OVL, 1, 0, ONE, 0, 0, 1,
                             mpa_pkg::STAT_RANGE, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_EIG, 0, 1, ONE, 0, 0, 1,
                             mpa_pkg::STAT_RANGE, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OCC, 1, 0, 0, 0, 1, 1,
                             mpa_pkg::STAT_RANGE, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RD_POP, 1, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_RANGE, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OVL, 0, 0, ONE, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_EIG, 0, 0, ONE, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OCC, 0, 0, 0, 0, 18'h20000, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RUN, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RD_POP, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 48'h0000_2000_0000));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OCC, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RUN, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OCC, 0, 0, 0, 0, 18'h3ffff, 0,
                             0, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RD_POP, 0, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_CFG, mpa_pkg::FUNC_RD_POP, 127, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_WR_OVL, 63, 0, VMIN, VMAX, 0, 1,
                             mpa_pkg::STAT_OK, 0, 0));
        dir_tab.push_back(mk(ROW_TXN, mpa_pkg::FUNC_RD_POP, 63, 0, 0, 0, 0, 1,
                             mpa_pkg::STAT_OK, 63, 0));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) begin
            s = dir_tab[k];
            if (s.kind == ROW_CFG) write_dimension(s.row);
            else send_txn(s.func, s.row[5:0], s.col, s.re, s.im, s.occ, s.chk, s.res);
        end

        foreach (dims[p]) begin
            write_dimension(dims[p]);
            no_idle = (p == 2 || p == 6);
            if (dim_n <= 8) fill_stores((dim_n == 8) ? FILL_MAX : FILL_RND);
            if (dim_n == 8) begin
                send_txn(mpa_pkg::FUNC_RUN, 0, 0, 0, 0, 0, 1'b0, '0);
                send_txn(mpa_pkg::FUNC_RUN, 0, 0, 0, 0, 0, 1'b0, '0);
            end
            repeat (40) random_txn();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/mpa_pkg.sv
rtl/core/mpa_qmul.sv
rtl/core/mulliken_population_accumulate_unit.sv
test/mulliken_population_accumulate_unit_tb.sv
